@@ rtl/delta_list_task_scheduler_defines.svh @@
// Assertion macros shared by the delta list scheduler.
`ifndef DELTA_LIST_TASK_SCHEDULER_DEFINES_SVH
`define DELTA_LIST_TASK_SCHEDULER_DEFINES_SVH
// Checks that a property holds on every clock edge outside reset.
`define DLTS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checks that a condition never holds on a clock edge outside reset.
`define DLTS_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`endif

@@ rtl/dlts_pkg.sv @@
// Package with types and constants of the delta list scheduler.
package dlts_pkg;
	localparam int MaxTasks = 16;
	localparam int DelayBits = 16;
	localparam int SlotBits = $clog2(MaxTasks);
	localparam int CountBits = $clog2(MaxTasks + 1);
	localparam int ResultCap = 16;
	localparam int ResBits = $clog2(ResultCap + 1);

	typedef logic [1:0] cmd_t;
	localparam cmd_t CmdTick = 2'd0;
	localparam cmd_t CmdAdd = 2'd1;
	localparam cmd_t CmdDel = 2'd2;
	localparam cmd_t CmdDisp = 2'd3;

	typedef logic [1:0] stat_t;
	localparam stat_t StOk = 2'd0;
	localparam stat_t StFull = 2'd1;
	localparam stat_t StNotFound = 2'd2;
	localparam stat_t StNone = 2'd3;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] task_handle;
		logic [15:0] delay;
		logic [15:0] period;
		logic [7:0] task_id;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] out_handle;
		logic [7:0] out_id;
		logic last;
	} out_item_t;

	typedef struct packed {
		logic [DelayBits-1:0] delta;
		logic [DelayBits-1:0] period;
		logic [7:0] id;
		logic [7:0] handle;
		logic [SlotBits-1:0] link;
	} entry_t;

	typedef struct packed {
		logic re;
		logic [SlotBits-1:0] raddr;
		logic we;
		logic [SlotBits-1:0] waddr;
		entry_t wdata;
	} mem_req_t;

	typedef enum logic [3:0] {
		S_IDLE, S_TICK_RD, S_TICK_WR,
		S_ADD_RD, S_ADD_CHK, S_ADD_WR, S_ADD_FIX,
		S_DEL_RD, S_DEL_CHK, S_DEL_NXT, S_DEL_FIX,
		S_DIS_RD, S_DIS_CHK, S_DIS_NXT, S_DIS_FIX, S_DONE
	} state_t;
endpackage

@@ rtl/delta_list_task_scheduler.sv @@
// Top level of the delta list timer scheduler; one command is processed at a time.
// Add and delete walk the list one entry at a time; dispatch takes each due task off the head
// and re-adds each periodic one by an add walk. The final strobe starts in the cycle after the
// sequencer goes idle, and the next command is taken in the cycle after it ends; the receiver
// cannot stall. Reset empties the list: head, count and ID counter clear, every slot is free.
module delta_list_task_scheduler (
	input logic clk,
	input logic arst_n,
	input logic start,
	input dlts_pkg::in_item_t cmd_in,
	output logic busy,
	output logic done,
	output dlts_pkg::out_item_t result
);
	// Memory request and read data between the sequencer and the slot memory.
	dlts_pkg::mem_req_t req;
	dlts_pkg::entry_t rdata;
	dlts_pkg::out_item_t raw_res;
	logic raw_done;
	logic ctrl_busy;
	logic ctrl_busy_q;
	// High in the cycle after the sequencer finished a dispatch that sent due tasks.
	logic fin;
	// Dispatch results are held back one strobe so the final one can carry last.
	dlts_pkg::out_item_t hold_q;
	logic hold_v_q;
	logic done_q;
	dlts_pkg::out_item_t res_q;

	dlts_mem u_mem (
		.clk(clk),
		.req(req),
		.rdata(rdata)
	);

	// The sequencer only sees a start when this level accepts the transaction.
	dlts_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start && !busy),
		.cmd_in(cmd_in),
		.busy(ctrl_busy),
		.done(raw_done),
		.result(raw_res),
		.req(req),
		.rdata(rdata)
	);

	assign fin = ctrl_busy_q && !ctrl_busy && hold_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_busy_q <= 1'b0;
			hold_v_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			ctrl_busy_q <= ctrl_busy;
			// A due task pushes out the one held before it; a closing result passes
			// straight through; the end of a dispatch flushes the held one as last.
			done_q <= (raw_done && (raw_res.last || hold_v_q)) || fin;
			if (raw_done && !raw_res.last) begin
				hold_v_q <= 1'b1;
			end else if (fin) begin
				hold_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (raw_done && !raw_res.last) begin
			hold_q <= raw_res;
		end
		priority if (raw_done && raw_res.last) begin
			res_q <= raw_res;
		end else if (raw_done && hold_v_q) begin
			res_q <= hold_q;
		end else if (fin) begin
			res_q <= '{status: hold_q.status, out_handle: hold_q.out_handle,
				out_id: hold_q.out_id, last: 1'b1};
		end
	end

	// Busy covers the walk and every result of the transaction still on its way out.
	assign busy = ctrl_busy || raw_done || hold_v_q || done_q;
	assign done = done_q;
	assign result = res_q;
endmodule

@@ rtl/dlts_mem.sv @@
// Slot memory holding one list entry per slot, with registered read data.
module dlts_mem (
	input logic clk,
	input dlts_pkg::mem_req_t req,
	output dlts_pkg::entry_t rdata
);
	dlts_pkg::entry_t mem [dlts_pkg::MaxTasks];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end
endmodule

@@ rtl/dlts_ctrl.sv @@
// Sequencer that walks the delta list for every command but tick, which only touches the head.
`include "delta_list_task_scheduler_defines.svh"
module dlts_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	input dlts_pkg::in_item_t cmd_in,
	output logic busy,
	output logic done,
	output dlts_pkg::out_item_t result,
	output dlts_pkg::mem_req_t req,
	input dlts_pkg::entry_t rdata
);
	localparam int SB = dlts_pkg::SlotBits;
	localparam int CB = dlts_pkg::CountBits;
	localparam int DB = dlts_pkg::DelayBits;
	localparam logic [DB-1:0] DMax = {DB{1'b1}};

	dlts_pkg::state_t state_q, state_d;
	dlts_pkg::in_item_t item_q;
	logic [SB-1:0] head_q, cur_q, prev_q, slot_q;
	logic [CB-1:0] count_q, k_q;
	logic [dlts_pkg::MaxTasks-1:0] free_q;
	logic [7:0] idc_q;
	logic has_prev_q;
	logic [DB-1:0] d_q;
	logic [DB-1:0] cur_delta_q;
	dlts_pkg::entry_t ent_q;
	logic [dlts_pkg::ResBits-1:0] n_q;
	logic requeue_q;
	dlts_pkg::out_item_t res_q;
	logic done_q;

	// Lowest free slot.
	logic [SB-1:0] free_slot;
	always_comb begin
		free_slot = '0;
		for (int i = dlts_pkg::MaxTasks - 1; i >= 0; i--) begin
			if (free_q[i]) begin
				free_slot = SB'(i);
			end
		end
	end

	logic [DB:0] fold_sum;
	assign fold_sum = {1'b0, rdata.delta} + {1'b0, cur_delta_q};

	assign busy = (state_q != dlts_pkg::S_IDLE);
	assign done = done_q;
	assign result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dlts_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		req = '0;
		unique case (state_q)
			dlts_pkg::S_IDLE: begin
				if (start) begin
					unique case (cmd_in.command)
						dlts_pkg::CmdTick: state_d = dlts_pkg::S_TICK_RD;
						dlts_pkg::CmdAdd: state_d = dlts_pkg::S_ADD_RD;
						dlts_pkg::CmdDel: state_d = dlts_pkg::S_DEL_RD;
						default: state_d = dlts_pkg::S_DIS_RD;
					endcase
				end
			end
			dlts_pkg::S_TICK_RD: begin
				req.re = 1'b1;
				req.raddr = head_q;
				state_d = dlts_pkg::S_TICK_WR;
			end
			dlts_pkg::S_TICK_WR: begin
				if (count_q != '0 && rdata.delta != '0) begin
					req.we = 1'b1;
					req.waddr = head_q;
					req.wdata = rdata;
					req.wdata.delta = rdata.delta - 1'b1;
				end
				state_d = dlts_pkg::S_DONE;
			end
			dlts_pkg::S_ADD_RD: begin
				if (count_q == CB'(dlts_pkg::MaxTasks)) begin
					state_d = dlts_pkg::S_DONE;
				end else if (k_q < count_q) begin
					req.re = 1'b1;
					req.raddr = cur_q;
					state_d = dlts_pkg::S_ADD_CHK;
				end else begin
					state_d = dlts_pkg::S_ADD_WR;
				end
			end
			dlts_pkg::S_ADD_CHK: begin
				if (d_q >= rdata.delta) begin
					state_d = dlts_pkg::S_ADD_RD;
				end else begin
					// Successor keeps its slot; its delta shrinks by the new delta.
					req.we = 1'b1;
					req.waddr = cur_q;
					req.wdata = rdata;
					req.wdata.delta = rdata.delta - d_q;
					state_d = dlts_pkg::S_ADD_WR;
				end
			end
			dlts_pkg::S_ADD_WR: begin
				req.we = 1'b1;
				req.waddr = free_slot;
				req.wdata.delta = d_q;
				req.wdata.period = ent_q.period;
				req.wdata.id = ent_q.id;
				req.wdata.handle = ent_q.handle;
				req.wdata.link = (k_q < count_q) ? cur_q : '0;
				if (has_prev_q) begin
					req.re = 1'b1;
					req.raddr = prev_q;
					state_d = dlts_pkg::S_ADD_FIX;
				end else begin
					state_d = requeue_q ? dlts_pkg::S_DIS_RD : dlts_pkg::S_DONE;
				end
			end
			dlts_pkg::S_ADD_FIX: begin
				req.we = 1'b1;
				req.waddr = prev_q;
				req.wdata = rdata;
				req.wdata.link = slot_q;
				state_d = requeue_q ? dlts_pkg::S_DIS_RD : dlts_pkg::S_DONE;
			end
			dlts_pkg::S_DEL_RD: begin
				if (k_q < count_q) begin
					req.re = 1'b1;
					req.raddr = cur_q;
					state_d = dlts_pkg::S_DEL_CHK;
				end else begin
					state_d = dlts_pkg::S_DONE;
				end
			end
			dlts_pkg::S_DEL_CHK: begin
				if (rdata.id == item_q.task_id) begin
					if (has_prev_q) begin
						req.re = 1'b1;
						req.raddr = prev_q;
						state_d = dlts_pkg::S_DEL_NXT;
					end else if (k_q + 1'b1 < count_q) begin
						req.re = 1'b1;
						req.raddr = rdata.link;
						state_d = dlts_pkg::S_DEL_FIX;
					end else begin
						state_d = dlts_pkg::S_DONE;
					end
				end else begin
					state_d = dlts_pkg::S_DEL_RD;
				end
			end
			dlts_pkg::S_DEL_NXT: begin
				req.we = 1'b1;
				req.waddr = prev_q;
				req.wdata = rdata;
				req.wdata.link = slot_q;
				// The count already dropped, so a successor exists while k is below it.
				if (k_q < count_q) begin
					req.re = 1'b1;
					req.raddr = slot_q;
					state_d = dlts_pkg::S_DEL_FIX;
				end else begin
					state_d = dlts_pkg::S_DONE;
				end
			end
			dlts_pkg::S_DEL_FIX: begin
				req.we = 1'b1;
				req.waddr = slot_q;
				req.wdata = rdata;
				req.wdata.delta = fold_sum[DB] ? DMax : fold_sum[DB-1:0];
				state_d = dlts_pkg::S_DONE;
			end
			dlts_pkg::S_DIS_RD: begin
				if (n_q == dlts_pkg::ResBits'(dlts_pkg::ResultCap) || count_q == '0) begin
					state_d = dlts_pkg::S_DONE;
				end else begin
					req.re = 1'b1;
					req.raddr = head_q;
					state_d = dlts_pkg::S_DIS_CHK;
				end
			end
			dlts_pkg::S_DIS_CHK: begin
				if (rdata.delta != '0) begin
					state_d = dlts_pkg::S_DONE;
				end else if (count_q > CB'(1)) begin
					req.re = 1'b1;
					req.raddr = rdata.link;
					state_d = dlts_pkg::S_DIS_FIX;
				end else begin
					state_d = dlts_pkg::S_DIS_NXT;
				end
			end
			dlts_pkg::S_DIS_FIX: begin
				req.we = 1'b1;
				req.waddr = slot_q;
				req.wdata = rdata;
				req.wdata.delta = fold_sum[DB] ? DMax : fold_sum[DB-1:0];
				state_d = dlts_pkg::S_DIS_NXT;
			end
			dlts_pkg::S_DIS_NXT: begin
				state_d = (ent_q.period != '0) ? dlts_pkg::S_ADD_RD : dlts_pkg::S_DIS_RD;
			end
			default: begin
				state_d = dlts_pkg::S_IDLE;
			end
		endcase
	end

	// A strobe for every due task, and a closing one unless due tasks were sent.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == dlts_pkg::S_DIS_CHK && rdata.delta == '0) ||
				(state_q == dlts_pkg::S_DONE &&
				!(item_q.command == dlts_pkg::CmdDisp && n_q != '0));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			count_q <= '0;
			free_q <= '1;
			idc_q <= '0;
			requeue_q <= 1'b0;
		end else begin
			unique case (state_q)
				dlts_pkg::S_IDLE: begin
					if (start) begin
						item_q <= cmd_in;
						k_q <= '0;
						cur_q <= head_q;
						has_prev_q <= 1'b0;
						n_q <= '0;
						requeue_q <= 1'b0;
						res_q <= '{
							status: (cmd_in.command == dlts_pkg::CmdDel) ?
								dlts_pkg::StNotFound :
								(cmd_in.command == dlts_pkg::CmdAdd &&
								count_q == CB'(dlts_pkg::MaxTasks)) ?
								dlts_pkg::StFull : dlts_pkg::StOk,
							out_handle: 8'd0,
							out_id: (cmd_in.command == dlts_pkg::CmdAdd) ? idc_q + 8'd1 :
								(cmd_in.command == dlts_pkg::CmdDel) ? cmd_in.task_id :
								8'd0,
							last: 1'b0};
						d_q <= cmd_in.delay;
						ent_q.period <= cmd_in.period;
						ent_q.handle <= cmd_in.task_handle;
						ent_q.id <= idc_q + 8'd1;
						if (cmd_in.command == dlts_pkg::CmdAdd) begin
							idc_q <= idc_q + 8'd1;
						end
					end
				end
				dlts_pkg::S_ADD_CHK: begin
					if (d_q >= rdata.delta) begin
						d_q <= d_q - rdata.delta;
						prev_q <= cur_q;
						has_prev_q <= 1'b1;
						cur_q <= rdata.link;
						k_q <= k_q + 1'b1;
					end
				end
				dlts_pkg::S_ADD_WR: begin
					slot_q <= free_slot;
					free_q[free_slot] <= 1'b0;
					count_q <= count_q + 1'b1;
					if (!has_prev_q) begin
						head_q <= free_slot;
					end
				end
				dlts_pkg::S_DEL_CHK: begin
					if (rdata.id == item_q.task_id) begin
						res_q.status <= dlts_pkg::StOk;
						slot_q <= rdata.link;
						cur_delta_q <= rdata.delta;
						free_q[cur_q] <= 1'b1;
						count_q <= count_q - 1'b1;
						if (!has_prev_q) begin
							head_q <= (count_q == CB'(1)) ? '0 : rdata.link;
						end
					end else begin
						prev_q <= cur_q;
						has_prev_q <= 1'b1;
						cur_q <= rdata.link;
						k_q <= k_q + 1'b1;
					end
				end
				dlts_pkg::S_DEL_NXT: begin
					if (count_q == '0) begin
						head_q <= '0;
					end
				end
				dlts_pkg::S_DIS_CHK: begin
					if (rdata.delta == '0) begin
						slot_q <= rdata.link;
						cur_delta_q <= rdata.delta;
						free_q[head_q] <= 1'b1;
						count_q <= count_q - 1'b1;
						head_q <= (count_q == CB'(1)) ? '0 : rdata.link;
						ent_q.period <= rdata.period;
						ent_q.handle <= rdata.handle;
						d_q <= rdata.period;
						res_q <= '{status: dlts_pkg::StOk, out_handle: rdata.handle,
							out_id: rdata.id, last: 1'b0};
						n_q <= n_q + 1'b1;
					end
				end
				dlts_pkg::S_DIS_NXT: begin
					if (ent_q.period != '0) begin
						idc_q <= idc_q + 8'd1;
						ent_q.id <= idc_q + 8'd1;
						requeue_q <= 1'b1;
						k_q <= '0;
						cur_q <= head_q;
						has_prev_q <= 1'b0;
					end
				end
				dlts_pkg::S_DONE: begin
					if (item_q.command == dlts_pkg::CmdDisp && n_q == '0) begin
						res_q <= '{status: dlts_pkg::StNone, out_handle: 8'd0,
							out_id: 8'd0, last: 1'b1};
					end else begin
						res_q.last <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	`DLTS_ASSERT(a_count_range, clk, arst_n, count_q <= CB'(dlts_pkg::MaxTasks), "task count overflow")
	`DLTS_ASSERT(a_done_busy, clk, arst_n, (state_q == dlts_pkg::S_IDLE) |-> !done_q || $past(state_q) == dlts_pkg::S_DONE, "stray result")
	`DLTS_ASSERT(a_no_write_idle, clk, arst_n, (state_q == dlts_pkg::S_IDLE) |-> !req.we, "write while idle")
	`DLTS_NEVER(a_empty_head, clk, arst_n, count_q == '0 && head_q != '0, "head kept on empty list")
endmodule

@@ test/tb.sv @@
// Self-checking testbench for the delta list timer scheduler.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Behavioral copy of the scheduler: list kept in slots with links, like the block.
	class sched_board;
		bit [15:0] delta_q[16];
		bit [15:0] period_q[16];
		bit [7:0] id_q[16];
		bit [7:0] handle_q[16];
		bit [3:0] link_q[16];
		bit [3:0] head;
		int count;
		bit [15:0] free_slots;
		bit [7:0] id_ctr;
		dlts_pkg::out_item_t pending[$];
		int errors;
		int checked;

		function new();
			head = 0;
			count = 0;
			free_slots = 16'hFFFF;
			id_ctr = 0;
			errors = 0;
			checked = 0;
		endfunction

		function bit insert(bit [7:0] h, bit [15:0] d, bit [15:0] p, bit [7:0] id);
			int k;
			int cur;
			int prv;
			int s;
			bit has_prev;
			k = 0;
			cur = head;
			prv = 0;
			has_prev = 0;
			if (count >= dlts_pkg::MaxTasks)
				return 0;
			while (k < count && d >= delta_q[cur]) begin
				d -= delta_q[cur];
				prv = cur;
				has_prev = 1;
				cur = link_q[cur];
				k++;
			end
			s = 0;
			while (!free_slots[s])
				s++;
			free_slots[s] = 0;
			delta_q[s] = d;
			period_q[s] = p;
			id_q[s] = id;
			handle_q[s] = h;
			link_q[s] = (k < count) ? 4'(cur) : 4'd0;
			if (has_prev)
				link_q[prv] = 4'(s);
			else
				head = 4'(s);
			if (k < count)
				delta_q[cur] -= d;
			count++;
			return 1;
		endfunction

		function void unlink(int k, int cur, int prv, bit has_prev);
			int nxt;
			int sum;
			nxt = link_q[cur];
			if (has_prev)
				link_q[prv] = 4'(nxt);
			else
				head = 4'(nxt);
			if (k + 1 < count) begin
				sum = delta_q[nxt] + delta_q[cur];
				delta_q[nxt] = (sum > 65535) ? 16'hFFFF : 16'(sum);
			end
			free_slots[cur] = 1;
			count--;
			if (count == 0)
				head = 0;
		endfunction

		function void push(dlts_pkg::stat_t st, bit [7:0] h, bit [7:0] id, bit lst);
			dlts_pkg::out_item_t r;
			r.status = st;
			r.out_handle = h;
			r.out_id = id;
			r.last = lst;
			pending.push_back(r);
		endfunction

		// Works out the results that one accepted command causes.
		function void note_command(dlts_pkg::in_item_t c);
			int k;
			int cur;
			int prv;
			int n;
			bit has_prev;
			bit found;
			bit [3:0] s;
			bit [15:0] p;
			bit [7:0] h;
			case (c.command)
				dlts_pkg::CmdTick: begin
					if (count > 0 && delta_q[head] > 0)
						delta_q[head]--;
					push(dlts_pkg::StOk, 0, 0, 1);
				end
				dlts_pkg::CmdAdd: begin
					id_ctr++;
					push(insert(c.task_handle, c.delay, c.period, id_ctr) ?
						dlts_pkg::StOk : dlts_pkg::StFull, 0, id_ctr, 1);
				end
				dlts_pkg::CmdDel: begin
					cur = head;
					prv = 0;
					has_prev = 0;
					found = 0;
					for (k = 0; k < count && !found; k++) begin
						if (id_q[cur] == c.task_id) begin
							unlink(k, cur, prv, has_prev);
							found = 1;
						end else begin
							prv = cur;
							has_prev = 1;
							cur = link_q[cur];
						end
					end
					push(found ? dlts_pkg::StOk : dlts_pkg::StNotFound, 0, c.task_id, 1);
				end
				default: begin
					n = 0;
					while (n < dlts_pkg::ResultCap && count > 0 && delta_q[head] == 0) begin
						s = head;
						h = handle_q[s];
						p = period_q[s];
						push(dlts_pkg::StOk, h, id_q[s], 0);
						n++;
						unlink(0, s, 0, 0);
						if (p != 0) begin
							id_ctr++;
							void'(insert(h, p, p, id_ctr));
						end
					end
					if (n == 0)
						push(dlts_pkg::StNone, 0, 0, 1);
					else
						pending[$].last = 1;
				end
			endcase
		endfunction

		function void check_result(dlts_pkg::out_item_t got);
			dlts_pkg::out_item_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %p", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			checked++;
			if (got !== want) begin
				$display("%0t: mismatch expected %p actual %p", $time, want, got);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	dlts_pkg::in_item_t cmd_in;
	logic busy;
	logic done;
	dlts_pkg::out_item_t result;
	sched_board board;
	int n_cmds;
	int n_disp_hits;
	bit [7:0] live_ids[$];

	delta_list_task_scheduler dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd_in(cmd_in),
		.busy(busy),
		.done(done),
		.result(result)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Every result is taken at the edge that ends its strobe cycle.
	always @(posedge clk) begin
		if (arst_n && done) begin
			board.check_result(result);
			if (result.status == dlts_pkg::StOk && result.out_handle != 0)
				n_disp_hits++;
		end
	end

	// Issues one command and returns at the edge after the transaction has been accepted.
	task automatic send(dlts_pkg::in_item_t c);
		start <= 1'b1;
		cmd_in <= c;
		do
			@(posedge clk);
		while (busy);
		board.note_command(c);
		if (c.command == dlts_pkg::CmdAdd)
			live_ids.push_back(board.id_ctr);
		n_cmds++;
		start <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_fields(dlts_pkg::cmd_t op, bit [7:0] h, bit [15:0] d, bit [15:0] p,
		bit [7:0] id);
		dlts_pkg::in_item_t c;
		c.command = op;
		c.task_handle = h;
		c.delay = d;
		c.period = p;
		c.task_id = id;
		send(c);
	endtask

	// Random command with a mix weighted toward adds and ticks so the list fills and drains.
	task automatic send_random();
		int pick;
		dlts_pkg::in_item_t c;
		c.command = dlts_pkg::CmdTick;
		c.task_handle = 8'($urandom);
		c.delay = 16'($urandom);
		c.period = 16'($urandom);
		c.task_id = 8'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			c.command = dlts_pkg::CmdTick;
		end else if (pick < 65) begin
			c.command = dlts_pkg::CmdAdd;
			// Mostly short delays so tasks come due; occasionally the full range.
			if ($urandom_range(0, 7) != 0)
				c.delay = 16'($urandom_range(0, 6));
			if ($urandom_range(0, 7) != 0)
				c.period = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom_range(1, 8));
		end else if (pick < 80) begin
			c.command = dlts_pkg::CmdDel;
			if (live_ids.size() > 0 && $urandom_range(0, 3) != 0)
				c.task_id = live_ids[$urandom_range(0, live_ids.size() - 1)];
		end else begin
			c.command = dlts_pkg::CmdDisp;
		end
		send(c);
	endtask

	// Waits until the block is idle and every expected result has been seen, or a guard runs out.
	task automatic drain();
		int guard;
		guard = 0;
		while ((board.pending.size() != 0 || busy) && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		repeat (20) @(posedge clk);
	endtask

	initial begin
		int i;
		int burst;
		board = new();
		n_cmds = 0;
		n_disp_hits = 0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd_in = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty-list cases, extremes, ties, deletes, full list.
		send_fields(dlts_pkg::CmdTick, 0, 0, 0, 0);
		send_fields(dlts_pkg::CmdDisp, 0, 0, 0, 0);
		send_fields(dlts_pkg::CmdDel, 0, 0, 0, 8'hFF);
		send_fields(dlts_pkg::CmdAdd, 8'hFF, 16'hFFFF, 16'hFFFF, 0);
		send_fields(dlts_pkg::CmdAdd, 8'h01, 16'd0, 16'd0, 0);
		send_fields(dlts_pkg::CmdAdd, 8'hA5, 16'd0, 16'd3, 0);
		send_fields(dlts_pkg::CmdAdd, 8'h5A, 16'd2, 16'd0, 0);
		send_fields(dlts_pkg::CmdDisp, 0, 0, 0, 0);
		send_fields(dlts_pkg::CmdTick, 0, 0, 0, 0);
		send_fields(dlts_pkg::CmdTick, 0, 0, 0, 0);
		send_fields(dlts_pkg::CmdDel, 0, 0, 0, 8'd1);
		send_fields(dlts_pkg::CmdDel, 0, 0, 0, 8'd4);
		send_fields(dlts_pkg::CmdDisp, 0, 0, 0, 0);
		for (i = 0; i < 17; i++)
			send_fields(dlts_pkg::CmdAdd, i[7:0], 16'(16'h8000 + i),
				(i < 8) ? 16'd1 : 16'd0, 0);
		send_fields(dlts_pkg::CmdDel, 0, 0, 0, board.id_q[board.head]);
		drain();
		// Reset-free cleanup so the random phase starts from an empty list.
		while (board.count > 0)
			send_fields(dlts_pkg::CmdDel, 0, 0, 0, board.id_q[board.head]);
		drain();

		// Random part in bursts with idle gaps between some of them.
		i = 0;
		while (i < 135) begin
			burst = $urandom_range(1, 12);
			repeat (burst) begin
				send_random();
				i++;
			end
			if ($urandom_range(0, 2) != 0)
				repeat ($urandom_range(1, 20)) @(posedge clk);
		end
		drain();

		$display("Ran %0d commands, %0d results checked, %0d dispatched tasks.",
			n_cmds, board.checked, n_disp_hits);
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("Some tests failed");
		$finish;
	end
endmodule
